// File: hw/rtl/tbpf_pkg.sv
// Shared types and constants for the three-axis band-pass filter.
// Holds the controller state encoding, the command/status structs and CSR codes.
// No dependencies.
package tbpf_pkg;

   // Coefficient format: unsigned Q0.16
   localparam int COEF_W    = 16;
   localparam int FRAC_BITS = 16;

   // Number of axis inputs carried by every item
   localparam int NUM_IN_AXES = 3;

   // Configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_HP_ALPHA = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LP_ALPHA = 1'd1;

   // Coefficient reset values
   localparam logic [COEF_W-1:0] HP_ALPHA_RESET = 16'd58982;
   localparam logic [COEF_W-1:0] LP_ALPHA_RESET = 16'd32768;

   // Controller states, one-hot
   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_MUL_HP = 6'b000010,
      ST_ROUND  = 6'b000100,
      ST_MUL_LP = 6'b001000,
      ST_FINISH = 6'b010000,
      ST_WRITE  = 6'b100000
   } tbpf_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic capture;    // take the input item, form the difference term
      logic prime;      // load history from the item (first IMU sample)
      logic mul_hp;     // high-pass product and history product
      logic round_hp;   // round the high-pass product
      logic mul_lp;     // low-pass product plus history product
      logic finish;     // round, saturate, update history
      logic write_out;  // load the result into the output register
   } tbpf_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic primed;
      logic out_free;
   } tbpf_stat_type;

endpackage

// File: hw/rtl/tbpf_ctrl.sv
// Controller state machine for the three-axis band-pass filter.
// Sequences the datapath one item at a time; depends on tbpf_pkg.
module tbpf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_is_imu,
   output logic                    req_stall,
   input  tbpf_pkg::tbpf_stat_type stat,
   output tbpf_pkg::tbpf_cmd_type  cmd
);

   tbpf_pkg::tbpf_state_type state_ff, state_in;
   logic accept;

   // Take a new item only when idle
   assign req_stall = (state_ff != tbpf_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // Decode commands from the state
   always_comb begin
      cmd           = '0;
      cmd.capture   = accept;
      cmd.prime     = accept && req_is_imu && !stat.primed;
      cmd.mul_hp    = (state_ff == tbpf_pkg::ST_MUL_HP);
      cmd.round_hp  = (state_ff == tbpf_pkg::ST_ROUND);
      cmd.mul_lp    = (state_ff == tbpf_pkg::ST_MUL_LP);
      cmd.finish    = (state_ff == tbpf_pkg::ST_FINISH);
      cmd.write_out = (state_ff == tbpf_pkg::ST_WRITE) && stat.out_free;
   end

   // Advance the state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tbpf_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_is_imu && stat.primed) state_in = tbpf_pkg::ST_MUL_HP;
               else                           state_in = tbpf_pkg::ST_WRITE;
            end
         end
         tbpf_pkg::ST_MUL_HP: state_in = tbpf_pkg::ST_ROUND;
         tbpf_pkg::ST_ROUND:  state_in = tbpf_pkg::ST_MUL_LP;
         tbpf_pkg::ST_MUL_LP: state_in = tbpf_pkg::ST_FINISH;
         tbpf_pkg::ST_FINISH: state_in = tbpf_pkg::ST_WRITE;
         tbpf_pkg::ST_WRITE: begin
            if (stat.out_free) state_in = tbpf_pkg::ST_IDLE;
         end
         default: state_in = tbpf_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= tbpf_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

   // Filter sequence runs straight through to the write state
   a_finish_to_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == tbpf_pkg::ST_FINISH |=> state_ff == tbpf_pkg::ST_WRITE)
      else $error("finish not followed by write");

   // A non-IMU transfer skips the filter
   a_pass_to_write: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_is_imu) |=> state_ff == tbpf_pkg::ST_WRITE)
      else $error("passthrough item entered the filter sequence");

   // A filtered transfer needs a primed history
   a_filter_primed: assert property (@(posedge clock) disable iff (reset)
      (accept && req_is_imu && stat.primed) |=> state_ff == tbpf_pkg::ST_MUL_HP)
      else $error("primed IMU item did not start the filter");

   // A result write returns the controller to idle
   a_write_state: assert property (@(posedge clock) disable iff (reset)
      cmd.write_out |=> state_ff == tbpf_pkg::ST_IDLE)
      else $error("write did not return to idle");

endmodule

// File: hw/rtl/tbpf_datapath.sv
// Datapath for the three-axis band-pass filter: per-axis history, multiply lanes
// and the output register. Driven by tbpf_ctrl commands; depends on tbpf_pkg.
module tbpf_datapath #(
   parameter int AXES         = 3,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  tbpf_pkg::tbpf_cmd_type         cmd,
   output tbpf_pkg::tbpf_stat_type        stat,
   input  logic [tbpf_pkg::COEF_W-1:0]    hp_alpha,
   input  logic [tbpf_pkg::COEF_W-1:0]    lp_alpha,
   input  logic signed [SAMPLE_WIDTH-1:0] req_acc_x,
   input  logic signed [SAMPLE_WIDTH-1:0] req_acc_y,
   input  logic signed [SAMPLE_WIDTH-1:0] req_acc_z,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_out_x,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_out_y,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_out_z,
   output logic                           rsp_filtered
);

   localparam int SW    = SAMPLE_WIDTH;
   localparam int NA    = tbpf_pkg::NUM_IN_AXES;
   localparam int FB    = tbpf_pkg::FRAC_BITS;
   localparam int DW    = SW + 2;            // difference and high-pass width
   localparam int ACC_W = SW + 20;           // product / accumulator width
   localparam int QW    = SW + 4;            // rounded low-pass width
   localparam int CW    = tbpf_pkg::COEF_W + 2;  // signed coefficient width

   localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FB - 1);
   localparam logic [tbpf_pkg::COEF_W:0] ONE = (tbpf_pkg::COEF_W + 1)'(1) << FB;

   logic signed [SW-1:0]    x_in  [NA];
   logic signed [SW-1:0]    x_ff  [NA];
   logic signed [SW-1:0]    res_ff[NA];
   logic signed [SW-1:0]    pi_ff [NA];
   logic signed [SW-1:0]    po_ff [NA];
   logic signed [DW-1:0]    d_ff  [NA];
   logic signed [DW-1:0]    hp_ff [NA];
   logic signed [ACC_W-1:0] php_ff[NA];
   logic signed [ACC_W-1:0] ppo_ff[NA];
   logic signed [ACC_W-1:0] acc_ff[NA];
   logic signed [SW-1:0]    sat   [NA];
   logic                    primed_ff;
   logic                    filt_ff;
   logic                    rsp_valid_ff;
   logic signed [SW-1:0]    rsp_out_ff[NA];
   logic                    rsp_filt_ff;

   logic signed [CW-1:0] a_s, b_s, nb_s;

   assign x_in[0] = req_acc_x;
   assign x_in[1] = req_acc_y;
   assign x_in[2] = req_acc_z;

   // Coefficients as signed operands; one minus b is 65536 - b
   assign a_s  = $signed(CW'(hp_alpha));
   assign b_s  = $signed(CW'(lp_alpha));
   assign nb_s = $signed(CW'(ONE - (tbpf_pkg::COEF_W + 1)'(lp_alpha)));

   // Round the accumulator and clamp to the sample range
   always_comb begin
      logic signed [ACC_W-1:0] fin;
      logic signed [QW-1:0]    q;
      for (int j = 0; j < NA; j++) begin
         fin = acc_ff[j] + HALF;
         q   = fin[SW+19:FB];
         if (q[QW-1:SW-1] == '0 || q[QW-1:SW-1] == '1) sat[j] = q[SW-1:0];
         else if (q[QW-1])                             sat[j] = {1'b1, {(SW-1){1'b0}}};
         else                                          sat[j] = {1'b0, {(SW-1){1'b1}}};
      end
   end

   // Per-axis lanes
   always_ff @(posedge clock) begin
      logic signed [ACC_W-1:0] rnd;
      for (int j = 0; j < NA; j++) begin
         if (cmd.capture) begin
            x_ff[j]   <= x_in[j];
            res_ff[j] <= x_in[j];
            d_ff[j]   <= DW'(po_ff[j]) + DW'(x_in[j]) - DW'(pi_ff[j]);
         end
         if (j < AXES) begin
            if (cmd.mul_hp) begin
               php_ff[j] <= ACC_W'(a_s) * ACC_W'(d_ff[j]);
               ppo_ff[j] <= ACC_W'(nb_s) * ACC_W'(po_ff[j]);
            end
            if (cmd.round_hp) begin
               rnd = php_ff[j] + HALF;
               hp_ff[j] <= rnd[SW+17:FB];
            end
            if (cmd.mul_lp) begin
               acc_ff[j] <= ACC_W'(b_s) * ACC_W'(hp_ff[j]) + ppo_ff[j];
            end
            if (cmd.finish) begin
               res_ff[j] <= sat[j];
            end
         end
      end
   end

   // Hold the filter history
   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff <= 1'b0;
         for (int j = 0; j < NA; j++) begin
            pi_ff[j] <= '0;
            po_ff[j] <= '0;
         end
      end else begin
         if (cmd.prime) primed_ff <= 1'b1;
         for (int j = 0; j < NA; j++) begin
            if (j < AXES) begin
               if (cmd.prime) begin
                  pi_ff[j] <= x_in[j];
                  po_ff[j] <= x_in[j];
               end else if (cmd.finish) begin
                  pi_ff[j] <= x_ff[j];
                  po_ff[j] <= sat[j];
               end
            end
         end
      end
   end

   // Mark filtered results
   always_ff @(posedge clock) begin
      if (cmd.capture)     filt_ff <= 1'b0;
      else if (cmd.finish) filt_ff <= 1'b1;
   end

   // Output register: load on write, drop after the transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.write_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_out) begin
         for (int j = 0; j < NA; j++) rsp_out_ff[j] <= res_ff[j];
         rsp_filt_ff <= filt_ff;
      end
   end

   assign stat.primed   = primed_ff;
   assign stat.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_x    = rsp_out_ff[0];
   assign rsp_out_y    = rsp_out_ff[1];
   assign rsp_out_z    = rsp_out_ff[2];
   assign rsp_filtered = rsp_filt_ff;

endmodule

// File: hw/rtl/three_axis_bandpass_filter.sv
// A filtered IMU item runs through the multiply-high-pass, round, multiply-low-pass,
// finish and write states; a passthrough or priming item goes straight to write.
// The next item is accepted only once the controller is back in idle.
// A waiting result does not block the next input transfer.
// Reset (synchronous): coefficients to 58982 and 32768, history cleared, unprimed.
// Top level: coefficient registers, controller and datapath; depends on tbpf_pkg.
module three_axis_bandpass_filter #(
   parameter int AXES         = 3,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_is_imu,
   input  logic signed [SAMPLE_WIDTH-1:0]      req_acc_x,
   input  logic signed [SAMPLE_WIDTH-1:0]      req_acc_y,
   input  logic signed [SAMPLE_WIDTH-1:0]      req_acc_z,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]      rsp_out_x,
   output logic signed [SAMPLE_WIDTH-1:0]      rsp_out_y,
   output logic signed [SAMPLE_WIDTH-1:0]      rsp_out_z,
   output logic                                rsp_filtered,
   input  logic                                csr_write_en,
   input  logic [tbpf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tbpf_pkg::COEF_W-1:0]         csr_data
);

   logic [tbpf_pkg::COEF_W-1:0] hp_alpha_ff;
   logic [tbpf_pkg::COEF_W-1:0] lp_alpha_ff;
   tbpf_pkg::tbpf_cmd_type      cmd;
   tbpf_pkg::tbpf_stat_type     stat;

   // Coefficient registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hp_alpha_ff <= tbpf_pkg::HP_ALPHA_RESET;
         lp_alpha_ff <= tbpf_pkg::LP_ALPHA_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            tbpf_pkg::CSR_HP_ALPHA: hp_alpha_ff <= csr_data;
            tbpf_pkg::CSR_LP_ALPHA: lp_alpha_ff <= csr_data;
            default: ;
         endcase
      end
   end

   tbpf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_is_imu (req_is_imu),
      .req_stall  (req_stall),
      .stat       (stat),
      .cmd        (cmd)
   );

   tbpf_datapath #(
      .AXES         (AXES),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .hp_alpha     (hp_alpha_ff),
      .lp_alpha     (lp_alpha_ff),
      .req_acc_x    (req_acc_x),
      .req_acc_y    (req_acc_y),
      .req_acc_z    (req_acc_z),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_x    (rsp_out_x),
      .rsp_out_y    (rsp_out_y),
      .rsp_out_z    (rsp_out_z),
      .rsp_filtered (rsp_filtered)
   );

endmodule
